/* rtl/best_match_interface_lookup_assert.svh */
// ----------------------------------------------------------------------------
// best match interface lookup assertion macros
// property shorthands used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef BEST_MATCH_INTERFACE_LOOKUP_ASSERT_SVH
`define BEST_MATCH_INTERFACE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define BML_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bml assertion failed");

// next-cycle implication
`define BML_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bml assertion failed");

`endif

/* rtl/bml_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_pkg
// types, codes and helpers for the best match interface lookup
// ----------------------------------------------------------------------------
package bml_pkg;

    localparam int MAX_INTERFACES = 16;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int LEVEL_W = 2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_NONE    = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_NETWORK = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_SUBNET  = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_EXACT   = 2'd3;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] entry_index;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] entry_subnet_mask;
        logic [ADDR_W-1:0] query_address;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  match_index;
        logic [LEVEL_W-1:0] match_level;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] mask;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // classful network mask of an address
    function automatic logic [ADDR_W-1:0] classful_mask(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] m;
        priority casez (a[ADDR_W-1 -: 3])
            3'b0??:  m = 32'hFF00_0000;
            3'b10?:  m = 32'hFFFF_0000;
            3'b110:  m = 32'hFFFF_FF00;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

/* rtl/best_match_interface_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best match interface lookup
// interface table with classful best-match search, one entry per cycle
// ----------------------------------------------------------------------------
// usage:
//   s_valid/s_ready/s_data carry items; command write stores one table
//   entry and gives no result, command lookup scans entries 0 to
//   interface_count-1, capped at MAX_INTERFACES, and gives one result
//   on m_valid/m_ready/m_data. cfg_valid/cfg_ready/cfg_data load
//   interface_count; cfg_ready is always 1. the table sits in one memory
//   with a registered read, read once per entry; a lookup goes through
//   ST_SCAN and ST_RESULT to m_valid, and an exact hit ends the scan early;
//   one item is in work at a time, so a new lookup is not taken until the
//   last one's result has been loaded into the output register.
//   s_ready is high only while no item is in work; a finished result sits
//   in the output register, so a new item is taken while it waits.
//   a lookup whose result finds the output register still full waits
//   until m_ready frees it.
//   reset clears the control state and interface_count; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module best_match_interface_lookup (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bml_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bml_pkg::out_item_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bml_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int IDX_W = (bml_pkg::MAX_INTERFACES > 1) ?
                           $clog2(bml_pkg::MAX_INTERFACES) : 1;

    bml_pkg::entry_t table_mem [bml_pkg::MAX_INTERFACES];
    bml_pkg::entry_t rd_data_reg;

    bml_pkg::state_t state_reg, state_next;

    logic [bml_pkg::COUNT_W-1:0] count_reg;
    logic [bml_pkg::COUNT_W-1:0] limit_reg, limit_next;
    logic [bml_pkg::COUNT_W-1:0] issue_reg, issue_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic [bml_pkg::SLOT_W-1:0]  rd_slot_reg;
    logic [bml_pkg::ADDR_W-1:0]  query_reg, net_reg;
    logic [bml_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [bml_pkg::SLOT_W-1:0]  best_reg, best_next;
    logic                        m_valid_reg, m_valid_next;
    bml_pkg::out_item_t          m_data_reg;

    logic             s_fire;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             load_out;
    logic             hit_net, hit_sub, hit_exact;

    assign s_ready   = (state_reg == bml_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign wr_en   = s_fire && (s_data.command == bml_pkg::CMD_WRITE)
                     && (32'(s_data.entry_index) < 32'(bml_pkg::MAX_INTERFACES));
    assign wr_addr = IDX_W'(s_data.entry_index);
    assign rd_addr = IDX_W'(issue_reg);

    assign hit_net   = ((query_reg ^ rd_data_reg.address) & net_reg) == '0;
    assign hit_sub   = ((query_reg ^ rd_data_reg.address) & rd_data_reg.mask) == '0;
    assign hit_exact = rd_valid_reg && (query_reg == rd_data_reg.address);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= '{address: s_data.entry_address,
                                    mask:    s_data.entry_subnet_mask};
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bml_pkg::ST_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg   <= limit_next;
        issue_reg   <= issue_next;
        level_reg   <= level_next;
        best_reg    <= best_next;
        rd_slot_reg <= bml_pkg::SLOT_W'(issue_reg);
        if (s_fire) begin
            query_reg <= s_data.query_address;
            net_reg   <= bml_pkg::classful_mask(s_data.query_address);
        end
        if (load_out) begin
            m_data_reg.found       <= (level_reg != bml_pkg::LVL_NONE);
            m_data_reg.match_index <= best_reg;
            m_data_reg.match_level <= level_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        issue_next    = issue_reg;
        level_next    = level_reg;
        best_next     = best_reg;
        rd_valid_next = 1'b0;
        rd_en         = 1'b0;
        load_out      = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (state_reg)
            bml_pkg::ST_IDLE: begin
                if (s_fire && (s_data.command == bml_pkg::CMD_LOOKUP)) begin
                    limit_next = (32'(count_reg) > 32'(bml_pkg::MAX_INTERFACES))
                                 ? bml_pkg::COUNT_W'(bml_pkg::MAX_INTERFACES)
                                 : count_reg;
                    issue_next = '0;
                    level_next = bml_pkg::LVL_NONE;
                    best_next  = '0;
                    state_next = bml_pkg::ST_SCAN;
                end
            end
            bml_pkg::ST_SCAN: begin
                // compare the entry read last cycle
                if (rd_valid_reg && hit_net) begin
                    if (hit_exact) begin
                        level_next = bml_pkg::LVL_EXACT;
                        best_next  = rd_slot_reg;
                    end else if (hit_sub) begin
                        if (level_reg < bml_pkg::LVL_SUBNET) begin
                            level_next = bml_pkg::LVL_SUBNET;
                            best_next  = rd_slot_reg;
                        end
                    end else if (level_reg < bml_pkg::LVL_NETWORK) begin
                        level_next = bml_pkg::LVL_NETWORK;
                        best_next  = rd_slot_reg;
                    end
                end
                if (hit_exact) begin
                    state_next = bml_pkg::ST_RESULT;
                end else if (issue_reg < limit_reg) begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    issue_next    = issue_reg + 1'b1;
                end else if (!rd_valid_reg) begin
                    state_next = bml_pkg::ST_RESULT;
                end
            end
            bml_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = bml_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bml_pkg::ST_IDLE;
            end
        endcase
    end

`include "best_match_interface_lookup_assert.svh"

    `BML_ASSERT_NOW(a_read_only_in_scan, aclk, aresetn, rd_valid_reg, state_reg == bml_pkg::ST_SCAN)
    `BML_ASSERT_NOW(a_found_matches_level, aclk, aresetn, m_valid, m_data.found == (m_data.match_level != bml_pkg::LVL_NONE))
    `BML_ASSERT_NOW(a_miss_index_zero, aclk, aresetn, m_valid && !m_data.found, m_data.match_index == '0)
    `BML_ASSERT_NEXT(a_exact_ends_scan, aclk, aresetn, state_reg == bml_pkg::ST_SCAN && hit_exact, state_reg == bml_pkg::ST_RESULT && level_reg == bml_pkg::LVL_EXACT)

endmodule
